// ----- rtl/quat_from_rotation_matrix_macros.svh -----
// assertion macros for the rotation matrix to quaternion block
`ifndef QUAT_FROM_ROTATION_MATRIX_MACROS_SVH
`define QUAT_FROM_ROTATION_MATRIX_MACROS_SVH
`ifndef SYNTH
`define QFRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QFRM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/qfrm_pkg.sv -----
// shared types and codes for the rotation matrix to quaternion block
`default_nettype none
package qfrm_pkg;
    localparam logic [1:0] PATH_TRACE = 2'd0;
    localparam logic [1:0] PATH_DIAG0 = 2'd1;
    localparam logic [1:0] PATH_DIAG1 = 2'd2;
    localparam logic [1:0] PATH_DIAG2 = 2'd3;

    // side information that travels with each transaction
    typedef struct packed {
        logic [1:0] path;
        logic       clamped;
        logic [2:0] neg;
    } t_ctl;
endpackage
`default_nettype wire

// ----- rtl/qfrm_if.sv -----
// matrix input and quaternion output channel interfaces
`default_nettype none
interface qfrm_mat_if #(parameter int DW = 24);
    logic valid;
    logic ready;
    logic signed [DW-1:0] m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2, m_2_0, m_2_1, m_2_2;
    modport source (output valid, m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2,
                    m_2_0, m_2_1, m_2_2, input ready);
    modport sink (input valid, m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2,
                  m_2_0, m_2_1, m_2_2, output ready);
endinterface

interface qfrm_quat_if #(parameter int DW = 24);
    logic valid;
    logic ready;
    logic signed [DW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic [1:0] path_taken;
    logic       root_clamped;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, path_taken,
                    root_clamped, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, path_taken,
                  root_clamped, output ready);
endinterface
`default_nettype wire

// ----- rtl/quat_from_rotation_matrix.sv -----
// rotation matrix to quaternion conversion, fully pipelined
// throughput: one transaction per cycle unless stalled; one root or quotient bit per stage
// a stalled output holds the whole pipeline, nothing is lost or repeated
// synchronous active-low reset clears all stage valid bits
`default_nettype none
`include "quat_from_rotation_matrix_macros.svh"
module quat_from_rotation_matrix #(
    parameter int DATA_WIDTH = 24,
    parameter int FRAC_BITS  = 16
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    qfrm_mat_if.sink   i_mat,
    qfrm_quat_if.source o_quat
);
    import qfrm_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int AW   = DW + 2;
    localparam int SW   = 2 * ((DW + FRAC_BITS + 2) / 2);
    localparam int RW   = SW / 2;
    localparam int NW   = DW + 1 + FRAC_BITS;
    localparam int LAST = RW + NW + 1;
    localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;
    localparam logic [NW-1:0] MAG_HI = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [NW-1:0] MAG_LO = {{(NW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    logic          en;
    logic          r_vld [0:LAST];
    t_ctl          r_ctl [0:LAST-1];
    logic [NW-1:0] r_num [0:LAST-1][3];
    logic [RW-1:0] r_root [1:LAST-1];
    logic [SW-1:0] r_rad [0:RW-1];
    logic [RW+1:0] r_srem [1:RW-1];
    logic [RW:0]   r_drem [RW+1:LAST-1][3];
    logic signed [DW-1:0] r_qx, r_qy, r_qz, r_qw;
    logic [1:0]    r_path;
    logic          r_clamped;

    // whole pipeline advances unless a finished result is held
    assign en = !r_vld[LAST] || o_quat.ready;
    assign i_mat.ready = en;

    // saturate a sign and magnitude to the signed output range
    function automatic logic signed [DW-1:0] sat(input logic neg, input logic [NW-1:0] mag);
        logic signed [DW-1:0] res;
        if (!neg) begin
            res = (mag > MAG_HI) ? MAG_HI[DW-1:0] : mag[DW-1:0];
        end else begin
            res = (mag > MAG_LO) ? MAG_LO[DW-1:0] : -(mag[DW-1:0]);
        end
        return res;
    endfunction

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g <= LAST; g++) r_vld[g] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_mat.valid;
            for (int g = 1; g <= LAST; g++) r_vld[g] <= r_vld[g-1];
        end
    end

    // front stage: path choice, root argument and numerators
    logic signed [AW-1:0] d0, d1, d2, tr, arg, n_a, n_b, n_c;
    logic signed [AW-1:0] e01, e02, e10, e12, e20, e21;
    logic [AW-1:0]        mag_a, mag_b, mag_c;
    logic [1:0]           n_path;
    logic                 n_clamp;
    always_comb begin
        d0  = AW'(i_mat.m_0_0);
        d1  = AW'(i_mat.m_1_1);
        d2  = AW'(i_mat.m_2_2);
        e01 = AW'(i_mat.m_0_1);
        e02 = AW'(i_mat.m_0_2);
        e10 = AW'(i_mat.m_1_0);
        e12 = AW'(i_mat.m_1_2);
        e20 = AW'(i_mat.m_2_0);
        e21 = AW'(i_mat.m_2_1);
        tr  = d0 + d1 + d2;
        if (tr > 0) begin
            n_path = PATH_TRACE;
        end else if (d2 > ((d1 > d0) ? d1 : d0)) begin
            n_path = PATH_DIAG2;
        end else if (d1 > d0) begin
            n_path = PATH_DIAG1;
        end else begin
            n_path = PATH_DIAG0;
        end
        case (n_path)
            PATH_TRACE: begin
                arg = tr + ONE;
                n_a = e12 - e21; n_b = e20 - e02; n_c = e01 - e10;
            end
            PATH_DIAG0: begin
                arg = d0 - (d1 + d2) + ONE;
                n_a = e12 - e21; n_b = e01 + e10; n_c = e02 + e20;
            end
            PATH_DIAG1: begin
                arg = d1 - (d2 + d0) + ONE;
                n_a = e20 - e02; n_b = e12 + e21; n_c = e10 + e01;
            end
            default: begin
                arg = d2 - (d0 + d1) + ONE;
                n_a = e01 - e10; n_b = e20 + e02; n_c = e21 + e12;
            end
        endcase
        n_clamp = arg[AW-1];
        if (n_clamp) arg = '0;
        mag_a = n_a[AW-1] ? -n_a : n_a;
        mag_b = n_b[AW-1] ? -n_b : n_b;
        mag_c = n_c[AW-1] ? -n_c : n_c;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0]    <= '{path: n_path, clamped: n_clamp,
                             neg: {n_c[AW-1], n_b[AW-1], n_a[AW-1]}};
            r_rad[0]    <= SW'({arg[AW-2:0], {FRAC_BITS{1'b0}}});
            r_num[0][0] <= {mag_a[DW:0], {FRAC_BITS{1'b0}}};
            r_num[0][1] <= {mag_b[DW:0], {FRAC_BITS{1'b0}}};
            r_num[0][2] <= {mag_c[DW:0], {FRAC_BITS{1'b0}}};
        end
    end

    // root stages: two radicand bits per stage
    for (genvar k = 1; k <= RW; k++) begin : g_sqrt
        logic [RW+1:0] sh, trial;
        logic [RW-1:0] prev_root;
        logic          ge;
        always_comb begin
            prev_root = (k == 1) ? '0 : r_root[(k == 1) ? 1 : k-1];
            sh = (k == 1) ? {{RW{1'b0}}, r_rad[k-1][SW-1:SW-2]}
                          : {r_srem[(k == 1) ? 1 : k-1][RW-1:0], r_rad[k-1][SW-1:SW-2]};
            trial = {prev_root, 2'b01};
            ge = sh >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctl[k]  <= r_ctl[k-1];
                r_num[k]  <= r_num[k-1];
                r_root[k] <= {prev_root[RW-2:0], ge};
            end
        end
        if (k < RW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rad[k]  <= {r_rad[k-1][SW-3:0], 2'b00};
                    r_srem[k] <= ge ? sh - trial : sh;
                end
            end
        end
    end

    // division stages: one quotient bit per stage in each of three lanes
    for (genvar g = RW+1; g <= RW+NW; g++) begin : g_div
        logic [RW+1:0] dv;
        assign dv = {1'b0, r_root[g-1], 1'b0};
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [RW+1:0] sh, diff;
            logic          ge;
            always_comb begin
                sh = (g == RW+1) ? {{(RW+1){1'b0}}, r_num[g-1][l][NW-1]}
                                 : {r_drem[(g == RW+1) ? RW+2 : g-1][l], r_num[g-1][l][NW-1]};
                ge = sh >= dv;
                diff = ge ? sh - dv : sh;
            end
            // each lane keeps its own remainder chain
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_num[g][l]  <= {r_num[g-1][l][NW-2:0], ge};
                    r_drem[g][l] <= diff[RW:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ctl[g]  <= r_ctl[g-1];
                r_root[g] <= r_root[g-1];
            end
        end
    end

    // output stage: saturation and component placement
    logic signed [DW-1:0] qa, qb, qc, qr;
    logic                 zr;
    always_comb begin
        zr = (r_root[LAST-1] == '0);
        qr = sat(1'b0, NW'(r_root[LAST-1] >> 1));
        qa = zr ? '0 : sat(r_ctl[LAST-1].neg[0], r_num[LAST-1][0]);
        qb = zr ? '0 : sat(r_ctl[LAST-1].neg[1], r_num[LAST-1][1]);
        qc = zr ? '0 : sat(r_ctl[LAST-1].neg[2], r_num[LAST-1][2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_path    <= r_ctl[LAST-1].path;
            r_clamped <= r_ctl[LAST-1].clamped;
            case (r_ctl[LAST-1].path)
                PATH_TRACE: begin r_qx <= qa; r_qy <= qb; r_qz <= qc; r_qw <= qr; end
                PATH_DIAG0: begin r_qx <= qr; r_qy <= qb; r_qz <= qc; r_qw <= qa; end
                PATH_DIAG1: begin r_qx <= qc; r_qy <= qr; r_qz <= qb; r_qw <= qa; end
                default:    begin r_qx <= qb; r_qy <= qc; r_qz <= qr; r_qw <= qa; end
            endcase
        end
    end

    assign o_quat.valid        = r_vld[LAST];
    assign o_quat.quat_x       = r_qx;
    assign o_quat.quat_y       = r_qy;
    assign o_quat.quat_z       = r_qz;
    assign o_quat.quat_w       = r_qw;
    assign o_quat.path_taken   = r_path;
    assign o_quat.root_clamped = r_clamped;

    // checks
    `QFRM_ASSERT_IMPL(a_trace_no_clamp, i_clk, i_rst_n,
        o_quat.valid && o_quat.path_taken == PATH_TRACE, !o_quat.root_clamped)
    `QFRM_ASSERT_IMPL(a_stall_holds_input, i_clk, i_rst_n,
        o_quat.valid && !o_quat.ready, !i_mat.ready)
    `QFRM_ASSERT_IMPL(a_clamp_zero, i_clk, i_rst_n, o_quat.valid && o_quat.root_clamped,
        o_quat.quat_x == 0 && o_quat.quat_y == 0 && o_quat.quat_z == 0 && o_quat.quat_w == 0)
endmodule
`default_nettype wire
